// ===== hdl/utw_pkg.sv =====
// Shared types, constants and the helper function of the UTF-8 text width measurer.
`default_nettype none

package utw_pkg;

	// Default sizes handed to the top level parameters.
	localparam int MAX_GLYPHS_DEF = 256;
	localparam int WIDTH_BITS_DEF = 8;
	localparam int SUM_BITS_DEF   = 16;

	// Width of the glyph count register.
	localparam int GLYPH_COUNT_BITS = 9;

	// Glyph shown for invalid or unknown characters.
	localparam logic [7:0] BAD_GLYPH = 8'h1A;

	// Result queue sizing.
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_PTR_BITS = 3;
	localparam int LEVEL_BITS    = 4;

	// Windows-1252 code points that map back to bytes 128..159.
	localparam int CP1252_COUNT = 27;
	localparam logic [15:0] CP1252_FROM [CP1252_COUNT] = '{
		16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
		16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
		16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178
	};
	localparam logic [7:0] CP1252_TO [CP1252_COUNT] = '{
		8'd128, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136, 8'd137,
		8'd138, 8'd139, 8'd140, 8'd142, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149,
		8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd155, 8'd156, 8'd158, 8'd159
	};

	// Input word: a table write or a text byte.
	typedef struct packed {
		logic       func;
		logic [7:0] glyph_index;
		logic [7:0] entry_width;
		logic [7:0] text_byte;
	} text_item_t;

	// Output word: one glyph result or one end-of-string result.
	typedef struct packed {
		logic [7:0]  glyph_code;
		logic [7:0]  char_width;
		logic [15:0] total_width;
		logic        saturated;
		logic        last;
	} result_item_t;

	// Decoder stage output.
	typedef struct packed {
		logic        valid;
		logic        emit_glyph;
		logic        bad;
		logic        emit_end;
		logic [20:0] code_point;
	} dec_t;

	// Lookup stage output.
	typedef struct packed {
		logic       valid;
		logic       emit_glyph;
		logic       emit_end;
		logic [7:0] glyph;
	} look_t;

	// Map a Windows-1252 code point back to its byte; others pass unchanged.
	function automatic logic [20:0] cp1252_remap(input logic [20:0] cp);
		logic [20:0] res;
		res = cp;
		for (int i = 0; i < CP1252_COUNT; i++) begin
			if (cp == {5'd0, CP1252_FROM[i]}) begin
				res = {13'd0, CP1252_TO[i]};
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/utw_decoder.sv =====
// Strict UTF-8 decoder state machine producing one result per completed character, rejected byte or NUL.
`default_nettype none

module utw_decoder
	import utw_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_en,
	input  wire logic [7:0] text_byte,
	output dec_t            dec_s1
);

	localparam logic [2:0] ST_ACCEPT = 3'd0;
	localparam logic [2:0] ST_NEED1  = 3'd1;
	localparam logic [2:0] ST_NEED2  = 3'd2;
	localparam logic [2:0] ST_NEED3  = 3'd3;
	localparam logic [2:0] ST_E0     = 3'd4;
	localparam logic [2:0] ST_ED     = 3'd5;
	localparam logic [2:0] ST_F0     = 3'd6;
	localparam logic [2:0] ST_F4     = 3'd7;

	logic [2:0]  state_q;
	logic [20:0] cp_q;
	logic [2:0]  state_n;
	logic [20:0] cp_n;
	logic [2:0]  follow;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic        bad;
	logic        done;
	logic        is_end;
	logic [20:0] cp_out;
	logic [20:0] cp_full;

	assign cp_full = {cp_q[14:0], text_byte[5:0]};

	// Next-state and character decode for one byte.
	always_comb begin
		state_n = ST_ACCEPT;
		cp_n    = '0;
		follow  = ST_ACCEPT;
		lo      = 8'h80;
		hi      = 8'hBF;
		bad     = 1'b0;
		done    = 1'b0;
		is_end  = 1'b0;
		cp_out  = '0;
		if (state_q == ST_ACCEPT) begin
			if (text_byte == 8'h00) begin
				is_end = 1'b1;
			end else if (text_byte inside {[8'h01:8'h7F]}) begin
				done   = 1'b1;
				cp_out = {13'd0, text_byte};
			end else if (text_byte inside {[8'hC2:8'hDF]}) begin
				state_n = ST_NEED1;
				cp_n    = {16'd0, text_byte[4:0]};
			end else if (text_byte inside {[8'hE0:8'hEF]}) begin
				cp_n = {17'd0, text_byte[3:0]};
				if (text_byte == 8'hE0) begin
					state_n = ST_E0;
				end else if (text_byte == 8'hED) begin
					state_n = ST_ED;
				end else begin
					state_n = ST_NEED2;
				end
			end else if (text_byte inside {[8'hF0:8'hF4]}) begin
				cp_n = {18'd0, text_byte[2:0]};
				if (text_byte == 8'hF0) begin
					state_n = ST_F0;
				end else if (text_byte == 8'hF4) begin
					state_n = ST_F4;
				end else begin
					state_n = ST_NEED3;
				end
			end else begin
				bad = 1'b1;
			end
		end else begin
			case (state_q)
				ST_NEED1: begin
					follow = ST_ACCEPT;
				end
				ST_NEED2: begin
					follow = ST_NEED1;
				end
				ST_NEED3: begin
					follow = ST_NEED2;
				end
				ST_E0: begin
					lo     = 8'hA0;
					follow = ST_NEED1;
				end
				ST_ED: begin
					hi     = 8'h9F;
					follow = ST_NEED1;
				end
				ST_F0: begin
					lo     = 8'h90;
					follow = ST_NEED2;
				end
				ST_F4: begin
					hi     = 8'h8F;
					follow = ST_NEED2;
				end
				default: begin
					lo = 8'h01;
					hi = 8'h00;
				end
			endcase
			if (text_byte < lo || text_byte > hi) begin
				// A rejecting byte is consumed; NUL also closes the string.
				bad    = 1'b1;
				is_end = (text_byte == 8'h00);
			end else if (follow == ST_ACCEPT) begin
				done   = 1'b1;
				cp_out = cp_full;
			end else begin
				state_n = follow;
				cp_n    = cp_full;
			end
		end
	end

	// Decoder state and partial code point.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			cp_q    <= '0;
		end else if (byte_en) begin
			state_q <= state_n;
			cp_q    <= cp_n;
		end
	end

	// Stage 1 register: what this byte emits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_s1 <= '0;
		end else begin
			dec_s1.valid      <= byte_en && (bad || done || is_end);
			dec_s1.emit_glyph <= bad || done;
			dec_s1.bad        <= bad;
			dec_s1.emit_end   <= is_end;
			dec_s1.code_point <= cp_out;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/utw_glyph_lookup.sv =====
// Code point to glyph mapping and the glyph width memory.
`default_nettype none

module utw_glyph_lookup
	import utw_pkg::*;
#(
	parameter int MAX_GLYPHS = MAX_GLYPHS_DEF,
	parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dec_t                        dec_s1,
	input  wire logic [GLYPH_COUNT_BITS-1:0] limit,
	input  wire logic                        wr_en,
	input  wire logic [7:0]                  wr_index,
	input  wire logic [7:0]                  wr_width,
	output look_t                            look_s2,
	output logic [WIDTH_BITS-1:0]            width_s2
);

	localparam int TABLE_DEPTH = (MAX_GLYPHS < 256) ? MAX_GLYPHS : 256;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);

	logic [WIDTH_BITS-1:0] width_mem_q [TABLE_DEPTH];
	logic [20:0]           mapped;
	logic [7:0]            glyph;
	logic                  wr_in_range;

	// Map the code point and apply the glyph count limit.
	always_comb begin
		mapped = cp1252_remap(dec_s1.code_point);
		if (dec_s1.bad) begin
			glyph = BAD_GLYPH;
		end else if (mapped < {12'd0, limit}) begin
			glyph = mapped[7:0];
		end else begin
			glyph = BAD_GLYPH;
		end
	end

	assign wr_in_range = ({1'b0, wr_index} < 9'(TABLE_DEPTH));

	// Width memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			width_mem_q[wr_index[ADDR_BITS-1:0]] <= WIDTH_BITS'(wr_width);
		end
		if (dec_s1.valid) begin
			width_s2 <= width_mem_q[glyph[ADDR_BITS-1:0]];
		end
	end

	// Stage 2 control register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_s2 <= '0;
		end else begin
			look_s2.valid      <= dec_s1.valid;
			look_s2.emit_glyph <= dec_s1.emit_glyph;
			look_s2.emit_end   <= dec_s1.emit_end;
			look_s2.glyph      <= glyph;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/utw_accum.sv =====
// Saturating width sum and the result queue that drives the output channel.
`default_nettype none

module utw_accum
	import utw_pkg::*;
#(
	parameter int WIDTH_BITS = WIDTH_BITS_DEF,
	parameter int SUM_BITS   = SUM_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire look_t                 look_s2,
	input  wire logic [WIDTH_BITS-1:0] width_s2,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_item_t               result,
	output logic [LEVEL_BITS-1:0]      level
);

	localparam int ADD_BITS = ((SUM_BITS > WIDTH_BITS) ? SUM_BITS : WIDTH_BITS) + 1;

	logic [SUM_BITS-1:0]      sum_q;
	logic                     ovf_q;
	logic [ADD_BITS-1:0]      add;
	logic [SUM_BITS-1:0]      sum_g;
	logic                     ovf_g;
	result_item_t             glyph_res;
	result_item_t             end_res;
	result_item_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [LEVEL_BITS-1:0]    level_q;
	logic                     pop;
	logic                     push_one;
	logic                     push_two;

	// Add this glyph's width and saturate.
	always_comb begin
		add   = ADD_BITS'(sum_q) + ADD_BITS'(width_s2);
		sum_g = sum_q;
		ovf_g = ovf_q;
		if (look_s2.emit_glyph) begin
			if (|add[ADD_BITS-1:SUM_BITS]) begin
				sum_g = '1;
				ovf_g = 1'b1;
			end else begin
				sum_g = add[SUM_BITS-1:0];
			end
		end
	end

	// Build the glyph result and the end-of-string result.
	always_comb begin
		glyph_res.glyph_code  = look_s2.glyph;
		glyph_res.char_width  = 8'(width_s2);
		glyph_res.total_width = 16'(sum_g);
		glyph_res.saturated   = ovf_g;
		glyph_res.last        = 1'b0;
		end_res.glyph_code    = 8'd0;
		end_res.char_width    = 8'd0;
		end_res.total_width   = 16'(sum_g);
		end_res.saturated     = ovf_g;
		end_res.last          = 1'b1;
	end

	// Running sum; cleared when a string ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (look_s2.valid) begin
			if (look_s2.emit_end) begin
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_g;
				ovf_q <= ovf_g;
			end
		end
	end

	assign pop      = result_valid && result_ready;
	assign push_one = look_s2.valid;
	assign push_two = look_s2.valid && look_s2.emit_glyph && look_s2.emit_end;

	// Queue storage; a rejected NUL writes two words in the same cycle.
	always_ff @(posedge clk) begin
		if (push_one) begin
			fifo_q[wr_ptr_q] <= look_s2.emit_glyph ? glyph_res : end_res;
		end
		if (push_two) begin
			fifo_q[wr_ptr_q + FIFO_PTR_BITS'(1)] <= end_res;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push_one) + FIFO_PTR_BITS'(push_two);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(pop);
			level_q  <= level_q + LEVEL_BITS'(push_one) + LEVEL_BITS'(push_two)
				- LEVEL_BITS'(pop);
		end
	end

	assign result_valid = (level_q != '0);
	assign result       = fifo_q[rd_ptr_q];
	assign level        = level_q;

endmodule

`default_nettype wire

// ===== hdl/utf8_text_width_measurer_core.sv =====
// Top level of the UTF-8 text width measurer.
//
// Usage: first load the glyph width table through the text channel with
// func 0, one entry per word. Then send the string one byte per word with
// func 1. Every decoded character yields a result word with its glyph, its
// width and the running sum; a NUL byte yields an end word with last set,
// after which the sum starts again from zero. A NUL that breaks an open
// sequence yields the 0x1A glyph word followed by the end word.
// The cfg channel writes the glyph count; it is always ready. It must be
// written only while the block is idle; the block itself does not enforce it.
// Path: a result word is offered once its byte has passed the stage 1
// register, the stage 2 register and the result queue write.
// Throughput: one input word per cycle while text_ready is high, set by
// the two-stage decode and table read path. An eight-word result queue
// sits before the output; text_ready drops when that queue could not hold
// two results for every word still in flight, so a stalled receiver stops
// the input and nothing is lost.
// Reset: decoder returns to its start state, the sum clears, the glyph count
// returns to min(MAX_GLYPHS, 256). Table contents are undefined until written.
`default_nettype none

module utf8_text_width_measurer_core
	import utw_pkg::*;
#(
	parameter int MAX_GLYPHS = MAX_GLYPHS_DEF,
	parameter int WIDTH_BITS = WIDTH_BITS_DEF,
	parameter int SUM_BITS   = SUM_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [GLYPH_COUNT_BITS-1:0] cfg_data,
	input  wire logic                        text_valid,
	output logic                             text_ready,
	input  wire text_item_t                  text,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output result_item_t                     result
);

	localparam int LIMIT_CAP_INT = (MAX_GLYPHS < 256) ? MAX_GLYPHS : 256;
	localparam logic [GLYPH_COUNT_BITS-1:0] LIMIT_CAP = GLYPH_COUNT_BITS'(LIMIT_CAP_INT);

	logic [GLYPH_COUNT_BITS-1:0] limit_q;
	logic                        text_take;
	logic                        byte_en;
	logic                        tbl_wr;
	dec_t                        dec_s1;
	look_t                       look_s2;
	logic [WIDTH_BITS-1:0]       width_s2;
	logic [LEVEL_BITS-1:0]       level;
	logic [LEVEL_BITS:0]         need;

	// Glyph count register, held already capped to the table size.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_CAP;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= (cfg_data > LIMIT_CAP) ? LIMIT_CAP : cfg_data;
		end
	end

	// Accept a word only if the queue has room for two results per word in flight.
	assign need = {1'b0, level}
		+ {{(LEVEL_BITS-1){1'b0}}, dec_s1.valid, 1'b0}
		+ {{(LEVEL_BITS-1){1'b0}}, look_s2.valid, 1'b0}
		+ (LEVEL_BITS+1)'(2);
	assign text_ready = (need <= (LEVEL_BITS+1)'(FIFO_DEPTH));
	assign text_take  = text_valid && text_ready;
	assign byte_en    = text_take && text.func;
	assign tbl_wr     = text_take && !text.func;

	utw_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_en),
		.text_byte (text.text_byte),
		.dec_s1    (dec_s1)
	);

	utw_glyph_lookup #(
		.MAX_GLYPHS (MAX_GLYPHS),
		.WIDTH_BITS (WIDTH_BITS)
	) u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.dec_s1   (dec_s1),
		.limit    (limit_q),
		.wr_en    (tbl_wr),
		.wr_index (text.glyph_index),
		.wr_width (text.entry_width),
		.look_s2  (look_s2),
		.width_s2 (width_s2)
	);

	utw_accum #(
		.WIDTH_BITS (WIDTH_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.look_s2      (look_s2),
		.width_s2     (width_s2),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.level        (level)
	);

	// A decoded character always reaches the lookup stage in the next cycle.
	a_stage_advance: assert property (@(posedge clk) disable iff (!arst_n)
		dec_s1.valid |=> look_s2.valid)
		else $error("decoded character lost between stages");

	// The queue never holds more words than it has entries.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= LEVEL_BITS'(FIFO_DEPTH))
		else $error("result queue overfilled");

	// A double result always finds two free entries.
	a_double_room: assert property (@(posedge clk) disable iff (!arst_n)
		(look_s2.valid && look_s2.emit_glyph && look_s2.emit_end)
		|-> (level <= LEVEL_BITS'(FIFO_DEPTH - 2)))
		else $error("no room for glyph and end words");

	// Words are accepted only while room is reserved for the pipeline.
	a_reserve: assert property (@(posedge clk) disable iff (!arst_n)
		text_take |=> (level <= LEVEL_BITS'(FIFO_DEPTH - 2)))
		else $error("input taken without queue reservation");

endmodule

`default_nettype wire

// ===== sim/utf8_text_width_measurer_core_tb.sv =====
// Self-checking testbench for the UTF-8 text width measurer core.
`default_nettype none

module utf8_text_width_measurer_core_tb
	import utw_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS_TARGET = 1550;
	localparam int MAX_REPORTS  = 40;
	localparam int SETTLE_CYCLES = 8;

	// Decoder states of the width predictor.
	typedef enum logic [2:0] {
		UTF_START,
		UTF_NEED1,
		UTF_NEED2,
		UTF_NEED3,
		UTF_AFTER_E0,
		UTF_AFTER_ED,
		UTF_AFTER_F0,
		UTF_AFTER_F4
	} utf_state_e;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [GLYPH_COUNT_BITS-1:0] cfg_data;
	logic text_valid;
	logic text_ready;
	text_item_t text;
	logic result_valid;
	logic result_ready;
	result_item_t result;

	// Predictor state: font table, glyph count, decoder and running width.
	logic [7:0] glyph_widths [256];
	int unsigned font_glyphs;
	utf_state_e utf_state;
	logic [20:0] code_acc;
	logic [15:0] width_total;
	logic width_clipped;
	result_item_t pending_results [$];

	// Run statistics.
	int items_sent;
	int table_writes;
	int results_seen;
	int strings_ended;
	int mismatches;
	logic calm_run;

	utf8_text_width_measurer_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text        (text),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Windows-1252 pairs: Unicode point in the upper bits, byte in the lower eight.
	function automatic logic [23:0] win1252_pair(input int i);
		case (i)
			0:  return {16'h20AC, 8'd128};
			1:  return {16'h201A, 8'd130};
			2:  return {16'h0192, 8'd131};
			3:  return {16'h201E, 8'd132};
			4:  return {16'h2026, 8'd133};
			5:  return {16'h2020, 8'd134};
			6:  return {16'h2021, 8'd135};
			7:  return {16'h02C6, 8'd136};
			8:  return {16'h2030, 8'd137};
			9:  return {16'h0160, 8'd138};
			10: return {16'h2039, 8'd139};
			11: return {16'h0152, 8'd140};
			12: return {16'h017D, 8'd142};
			13: return {16'h2018, 8'd145};
			14: return {16'h2019, 8'd146};
			15: return {16'h201C, 8'd147};
			16: return {16'h201D, 8'd148};
			17: return {16'h2022, 8'd149};
			18: return {16'h2013, 8'd150};
			19: return {16'h2014, 8'd151};
			20: return {16'h02DC, 8'd152};
			21: return {16'h2122, 8'd153};
			22: return {16'h0161, 8'd154};
			23: return {16'h203A, 8'd155};
			24: return {16'h0153, 8'd156};
			25: return {16'h017E, 8'd158};
			default: return {16'h0178, 8'd159};
		endcase
	endfunction

	// Code point to glyph: Windows-1252 remap, then the font size limit.
	function automatic logic [7:0] glyph_of(input logic [20:0] cp);
		logic [20:0] mapped;
		logic [23:0] pair;
		int unsigned limit;
		mapped = cp;
		for (int i = 0; i < 27; i++) begin
			pair = win1252_pair(i);
			if (cp == {5'd0, pair[23:8]}) begin
				mapped = {13'd0, pair[7:0]};
			end
		end
		limit = (font_glyphs > 256) ? 256 : font_glyphs;
		return ({11'd0, mapped} < limit) ? mapped[7:0] : BAD_GLYPH;
	endfunction

	// Add one glyph to the running width and queue its result word.
	task automatic add_glyph(input logic [7:0] glyph);
		result_item_t r;
		logic [16:0] sum;
		sum = {1'b0, width_total} + {9'd0, glyph_widths[glyph]};
		if (sum[16]) begin
			width_total = 16'hFFFF;
			width_clipped = 1'b1;
		end else begin
			width_total = sum[15:0];
		end
		r.glyph_code = glyph;
		r.char_width = glyph_widths[glyph];
		r.total_width = width_total;
		r.saturated = width_clipped;
		r.last = 1'b0;
		pending_results.push_back(r);
	endtask

	// Queue the end-of-string word and start a fresh sum.
	task automatic close_string();
		result_item_t r;
		r.glyph_code = 8'd0;
		r.char_width = 8'd0;
		r.total_width = width_total;
		r.saturated = width_clipped;
		r.last = 1'b1;
		pending_results.push_back(r);
		width_total = 16'd0;
		width_clipped = 1'b0;
	endtask

	// Predict the result words of one accepted input word.
	task automatic measure_word(input text_item_t w);
		logic [7:0] b;
		logic [7:0] lo;
		logic [7:0] hi;
		utf_state_e nxt;
		logic bad;
		logic complete;
		b = w.text_byte;
		lo = 8'h80;
		hi = 8'hBF;
		nxt = UTF_START;
		bad = 1'b0;
		complete = 1'b0;
		if (!w.func) begin
			glyph_widths[w.glyph_index] = w.entry_width;
			return;
		end
		if (utf_state == UTF_START) begin
			if (b < 8'h80) begin
				code_acc = {13'd0, b};
				complete = 1'b1;
			end else if (b < 8'hC2) begin
				bad = 1'b1;
			end else if (b < 8'hE0) begin
				code_acc = {16'd0, b[4:0]};
				utf_state = UTF_NEED1;
			end else if (b < 8'hF0) begin
				code_acc = {17'd0, b[3:0]};
				utf_state = (b == 8'hE0) ? UTF_AFTER_E0 :
					(b == 8'hED) ? UTF_AFTER_ED : UTF_NEED2;
			end else if (b < 8'hF5) begin
				code_acc = {18'd0, b[2:0]};
				utf_state = (b == 8'hF0) ? UTF_AFTER_F0 :
					(b == 8'hF4) ? UTF_AFTER_F4 : UTF_NEED3;
			end else begin
				bad = 1'b1;
			end
			if (!bad && !complete) return;
		end else begin
			case (utf_state)
				UTF_NEED1: nxt = UTF_START;
				UTF_NEED2: nxt = UTF_NEED1;
				UTF_NEED3: nxt = UTF_NEED2;
				UTF_AFTER_E0: begin
					lo = 8'hA0;
					nxt = UTF_NEED1;
				end
				UTF_AFTER_ED: begin
					hi = 8'h9F;
					nxt = UTF_NEED1;
				end
				UTF_AFTER_F0: begin
					lo = 8'h90;
					nxt = UTF_NEED2;
				end
				default: begin
					hi = 8'h8F;
					nxt = UTF_NEED2;
				end
			endcase
			if (b < lo || b > hi) begin
				bad = 1'b1;
			end else begin
				code_acc = {code_acc[14:0], b[5:0]};
				utf_state = nxt;
				if (nxt != UTF_START) return;
				complete = 1'b1;
			end
		end
		utf_state = UTF_START;
		if (bad) begin
			// A rejected byte is consumed; a NUL also ends the string.
			code_acc = 21'd0;
			add_glyph(BAD_GLYPH);
			if (b == 8'd0) close_string();
			return;
		end
		if (code_acc == 21'd0) begin
			close_string();
		end else begin
			add_glyph(glyph_of(code_acc));
			code_acc = 21'd0;
		end
	endtask

	// One line per mismatch; the count keeps going past the print cap.
	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
		end
		mismatches++;
	endtask

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (result.last) strings_ended++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word, glyph", 0,
					32'(result.glyph_code));
			end else begin
				want = pending_results.pop_front();
				if (result.glyph_code !== want.glyph_code)
					report_mismatch("glyph_code", 32'(want.glyph_code),
						32'(result.glyph_code));
				if (result.char_width !== want.char_width)
					report_mismatch("char_width", 32'(want.char_width),
						32'(result.char_width));
				if (result.total_width !== want.total_width)
					report_mismatch("total_width", 32'(want.total_width),
						32'(result.total_width));
				if (result.saturated !== want.saturated)
					report_mismatch("saturated", 32'(want.saturated),
						32'(result.saturated));
				if (result.last !== want.last)
					report_mismatch("last", 32'(want.last), 32'(result.last));
			end
		end
	end

	// Receiver stalls about 16 percent of the time unless a calm stretch runs.
	always @(negedge clk) begin
		result_ready <= calm_run || ($urandom_range(0, 99) >= 16);
	end

	// Send one input word, with random gaps before it; entered at a falling edge.
	task automatic send_word(input text_item_t w);
		while (!calm_run && $urandom_range(0, 99) < 16) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text <= w;
		do @(posedge clk); while (!text_ready);
		measure_word(w);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text_byte(input logic [7:0] b);
		text_item_t w;
		w.func = 1'b1;
		w.glyph_index = 8'($urandom_range(0, 255));
		w.entry_width = 8'($urandom_range(0, 255));
		w.text_byte = b;
		send_word(w);
	endtask

	task automatic send_table_word(input logic [7:0] index, input logic [7:0] width);
		text_item_t w;
		w.func = 1'b0;
		w.glyph_index = index;
		w.entry_width = width;
		w.text_byte = 8'($urandom_range(0, 255));
		send_word(w);
		table_writes++;
	endtask

	// UTF-8 encoding, first byte in the top eight bits; returns the length.
	function automatic int utf8_encode(input logic [20:0] cp, output logic [31:0] seq);
		seq = 32'd0;
		if (cp < 21'h80) begin
			seq[31:24] = cp[7:0];
			return 1;
		end else if (cp < 21'h800) begin
			seq[31:16] = {3'b110, cp[10:6], 2'b10, cp[5:0]};
			return 2;
		end else if (cp < 21'h10000) begin
			seq[31:8] = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
			return 3;
		end
		seq = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
		return 4;
	endfunction

	task automatic send_code_point(input logic [20:0] cp);
		logic [31:0] seq;
		int n;
		n = utf8_encode(cp, seq);
		for (int k = 0; k < n; k++) send_text_byte(seq[31-8*k -: 8]);
	endtask

	// Random valid code point, weighted toward glyphs the font can hold.
	function automatic logic [20:0] random_code_point();
		int unsigned cp;
		logic [23:0] pair;
		case ($urandom_range(0, 9))
			0, 1, 2: cp = $urandom_range(1, 'h7F);
			3: cp = $urandom_range('h80, 'hFF);
			4: begin
				pair = win1252_pair($urandom_range(0, 26));
				cp = 32'(pair[23:8]);
			end
			5: cp = $urandom_range('h100, 'h7FF);
			6, 7: begin
				do cp = $urandom_range('h800, 'hFFFF); while (cp >= 'hD800 && cp <= 'hDFFF);
			end
			default: cp = $urandom_range('h10000, 'h10FFFF);
		endcase
		return cp[20:0];
	endfunction

	// Leading bytes of a multi-byte character, never the whole of it.
	task automatic send_partial_char();
		logic [20:0] cp;
		logic [31:0] seq;
		int n;
		int cut;
		do cp = random_code_point(); while (cp < 21'h80);
		n = utf8_encode(cp, seq);
		cut = $urandom_range(1, n - 1);
		for (int k = 0; k < cut; k++) send_text_byte(seq[31-8*k -: 8]);
	endtask

	// Malformed input: noise, lone continuations, overlong, surrogate, too high, truncated.
	task automatic send_broken_sequence();
		case ($urandom_range(0, 8))
			0: send_text_byte(8'($urandom_range(0, 255)));
			1: send_text_byte(8'($urandom_range('h80, 'hBF)));
			2: begin
				send_text_byte(8'($urandom_range('hC0, 'hC1)));
				send_text_byte(8'($urandom_range('h80, 'hBF)));
			end
			3: begin
				send_text_byte(8'hE0);
				send_text_byte(8'($urandom_range('h80, 'h9F)));
				send_text_byte(8'($urandom_range('h80, 'hBF)));
			end
			4: begin
				send_text_byte(8'hED);
				send_text_byte(8'($urandom_range('hA0, 'hBF)));
				send_text_byte(8'($urandom_range('h80, 'hBF)));
			end
			5: begin
				send_text_byte(8'hF0);
				send_text_byte(8'($urandom_range('h80, 'h8F)));
				send_text_byte(8'($urandom_range('h80, 'hBF)));
			end
			6: begin
				send_text_byte(8'hF4);
				send_text_byte(8'($urandom_range('h90, 'hBF)));
				send_text_byte(8'($urandom_range('h80, 'hBF)));
			end
			7: send_text_byte(8'($urandom_range('hF5, 'hFF)));
			default: begin
				send_partial_char();
				send_text_byte(8'($urandom_range('h21, 'h7E)));
			end
		endcase
	endtask

	// Stop sending and wait until every predicted word has come out.
	task automatic wait_drained();
		text_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_glyph_count(input logic [GLYPH_COUNT_BITS-1:0] count);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		do @(posedge clk); while (!cfg_ready);
		font_glyphs = 32'(count);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Fill the whole font table so no glyph is ever read unwritten.
	task automatic test_table_load();
		for (int i = 0; i < 256; i++) begin
			send_table_word(i[7:0], (i == 0) ? 8'd0 : (i == 255) ? 8'd255 :
				8'($urandom_range(0, 255)));
		end
	endtask

	// Well-formed characters at the edges of each encoding length.
	task automatic test_decode_forms();
		send_code_point(21'h41);
		send_code_point(21'h7F);
		send_code_point(21'h80);
		send_code_point(21'hFF);
		send_code_point(21'h20AC);
		send_code_point(21'hFFFF);
		send_code_point(21'h10FFFF);
		send_text_byte(8'h00);
	endtask

	// Rejected bytes, then a NUL that breaks a sequence, then an empty string.
	task automatic test_reject_forms();
		send_text_byte(8'h80);
		send_text_byte(8'hC0);
		send_text_byte(8'hE0);
		send_text_byte(8'h80);
		send_text_byte(8'hED);
		send_text_byte(8'hA0);
		send_text_byte(8'hF4);
		send_text_byte(8'h90);
		send_text_byte(8'hFF);
		send_text_byte(8'hC3);
		send_text_byte(8'h00);
		send_text_byte(8'h00);
	endtask

	// Smallest font: only code points below 27 keep their own glyph.
	task automatic test_glyph_limit();
		wait_drained();
		write_glyph_count(9'd27);
		send_code_point(21'h1A);
		send_code_point(21'h1B);
		send_code_point(21'h20AC);
		send_text_byte(8'h00);
		wait_drained();
		write_glyph_count(9'd256);
	endtask

	// A long string of the widest glyph drives the sum into saturation.
	task automatic test_saturation();
		calm_run = 1'b1;
		send_table_word(8'h57, 8'd255);
		for (int i = 0; i < 260; i++) send_text_byte(8'h57);
		send_text_byte(8'h00);
		send_text_byte(8'h57);
		send_text_byte(8'h00);
		calm_run = 1'b0;
	endtask

	// One random string: mostly valid characters, some noise and table updates.
	task automatic send_random_string();
		int n;
		int roll;
		n = $urandom_range(0, 12);
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) send_table_word(8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			else if (roll < 24) send_broken_sequence();
			else send_code_point(random_code_point());
		end
		if ($urandom_range(0, 9) == 0) send_partial_char();
		send_text_byte(8'h00);
	endtask

	// Random strings under several font sizes, idle between settings.
	task automatic test_random_phases();
		logic [GLYPH_COUNT_BITS-1:0] counts [6];
		int phase_end;
		counts = '{9'd256, 9'd27, 9'd255, 9'd128, 9'd0, 9'd256};
		counts[4] = 9'($urandom_range(27, 256));
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			write_glyph_count(counts[p]);
			phase_end = items_sent + (ITEMS_TARGET - items_sent) / (6 - p);
			while (items_sent < phase_end) send_random_string();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		text_valid = 1'b0;
		text = '0;
		calm_run = 1'b0;
		items_sent = 0;
		table_writes = 0;
		results_seen = 0;
		strings_ended = 0;
		mismatches = 0;
		font_glyphs = 256;
		utf_state = UTF_START;
		code_acc = 21'd0;
		width_total = 16'd0;
		width_clipped = 1'b0;
		for (int i = 0; i < 256; i++) glyph_widths[i] = 8'd0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_glyph_count(9'd256);
		test_table_load();
		test_decode_forms();
		test_reject_forms();
		test_glyph_limit();
		test_saturation();
		test_random_phases();
		wait_drained();

		$display("Sent %0d words (%0d table writes) and checked %0d result words over %0d strings,",
			items_sent, table_writes, results_seen, strings_ended);
		$display("with font sizes 27 to 256, rejected forms, NUL inside sequences and saturation.");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#(5_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
